// ===== hw/rtl/acesfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ACES filmic tone map - shared package
// Field widths, curve coefficients and pipeline depth figures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acesfm_pkg;

	// Pixel channel widths
	localparam int CH_W  = 24;
	localparam int OUT_W = 17;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 56;

	// Default number of fraction bits on the input channels
	localparam int DEF_FRAC_BITS = 16;

	// Output code for 1.0 in Q1.16
	localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(65536);

	// Curve coefficients, scaled by 100
	localparam int unsigned C_NUM_SQ  = 251;
	localparam int unsigned C_NUM_LIN = 3;
	localparam int unsigned C_DEN_SQ  = 243;
	localparam int unsigned C_DEN_LIN = 59;
	localparam int unsigned C_DEN_K   = 14;

	// Divider shape: quotient bits and bits resolved per stage
	localparam int QUO_BITS   = 16;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STEPS  = QUO_BITS / BITS_PER_STAGE;

	// Stage counts
	localparam int CURVE_STAGES = 3;
	localparam int DIV_STAGES   = DIV_STEPS + 2;
	localparam int LATENCY      = CURVE_STAGES + DIV_STAGES;

endpackage

// ===== hw/rtl/acesfm_curve.sv =====
// ----------------------------------------------------------------------------
// ACES filmic tone map - curve terms
// Builds numerator and denominator of the rational curve for one channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acesfm_curve
	import acesfm_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int DW        = 57
) (
	input  logic            clk,
	input  logic            en,
	input  logic [CH_W-1:0] x,
	output logic [DW-1:0]   num,
	output logic [DW-1:0]   den
);

	localparam logic [DW-1:0] DEN_K = DW'(C_DEN_K) << (2 * FRAC_BITS);

	logic [2*CH_W-1:0] xx_s1;
	logic [DW-1:0]     xs_s1;
	logic [DW-1:0]     nsq_s2, nlin_s2, dsq_s2, dlin_s2;
	logic [DW-1:0]     num_s3, den_s3;

	// square and scaled linear term
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= (2*CH_W)'(x) * (2*CH_W)'(x);
			xs_s1 <= DW'(x) << FRAC_BITS;
		end
	end

	// constant weights
	always_ff @(posedge clk) begin
		if (en) begin
			nsq_s2  <= DW'(xx_s1) * DW'(C_NUM_SQ);
			nlin_s2 <= xs_s1 * DW'(C_NUM_LIN);
			dsq_s2  <= DW'(xx_s1) * DW'(C_DEN_SQ);
			dlin_s2 <= xs_s1 * DW'(C_DEN_LIN);
		end
	end

	// sums
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= nsq_s2 + nlin_s2;
			den_s3 <= dsq_s2 + dlin_s2 + DEN_K;
		end
	end

	assign num = num_s3;
	assign den = den_s3;

endmodule

// ===== hw/rtl/acesfm_div.sv =====
// ----------------------------------------------------------------------------
// ACES filmic tone map - fraction divider
// Pipelined restoring division of num/den to 16 fraction bits, round, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acesfm_div
	import acesfm_pkg::*;
#(
	parameter int DW = 57
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DW-1:0]    num,
	input  logic [DW-1:0]    den,
	output logic [OUT_W-1:0] result
);

	logic [DW-1:0]       rem_s [DIV_STEPS+1];
	logic [DW-1:0]       den_s [DIV_STEPS+1];
	logic [QUO_BITS-1:0] quo_s [DIV_STEPS+1];
	logic                sat_s [DIV_STEPS+1];
	logic [OUT_W-1:0]    res_q;

	// saturate when the curve reaches one
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= (num >= den);
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [DW-1:0]       rem_w;
		logic [QUO_BITS-1:0] quo_w;
		logic [DW:0]         shf;

		always_comb begin
			rem_w = rem_s[k-1];
			quo_w = quo_s[k-1];
			shf   = '0;
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				shf = {rem_w, 1'b0};
				if (shf >= {1'b0, den_s[k-1]}) begin
					rem_w = DW'(shf - {1'b0, den_s[k-1]});
					quo_w = {quo_w[QUO_BITS-2:0], 1'b1};
				end else begin
					rem_w = shf[DW-1:0];
					quo_w = {quo_w[QUO_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_w;
				quo_s[k] <= quo_w;
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	// round to nearest, ties up; clamp to one
	logic             rnd_up;
	logic [OUT_W-1:0] rounded;

	always_comb begin
		rnd_up  = ({rem_s[DIV_STEPS], 1'b0} >= {1'b0, den_s[DIV_STEPS]});
		rounded = {1'b0, quo_s[DIV_STEPS]} + OUT_W'(rnd_up);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[DIV_STEPS] || (rounded > OUT_ONE)) begin
				res_q <= OUT_ONE;
			end else begin
				res_q <= rounded;
			end
		end
	end

	assign result = res_q;

endmodule

// ===== hw/rtl/aces_filmic_tone_map.sv =====
// ----------------------------------------------------------------------------
// ACES filmic tone map - top level
// An accepted input beat passes 3 curve stages, 1 compare stage,
// 8 divider stages and 1 round stage on its way to its output beat.
// Throughput: one pixel per cycle while the output is not stalled; the
// 2-bit-per-stage divider pipeline sets the depth. The whole pipe holds only while the output beat waits.
// Reset (arst_n low, asynchronous) clears all valid bits; data regs are
// not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aces_filmic_tone_map
	import acesfm_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
	input  logic                   s_axis_tlast,   // last_in
	// master side
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out, pad
	output logic                   m_axis_tlast    // last_out
);

	// Numerator and denominator width: 316 * max(X^2, S^2) fits in 2*w+9 bits
	localparam int DW = 2 * ((FRAC_BITS > CH_W) ? FRAC_BITS : CH_W) + 9;

	logic                 en;
	logic                 vld_q  [LATENCY];
	logic                 last_q [LATENCY];
	logic [CH_W-1:0]      ch_in  [3];
	logic [OUT_W-1:0]     ch_out [3];

	// Advance the whole pipe unless the output beat is stalled.
	assign en            = !vld_q[LATENCY-1] || m_axis_tready;
	assign s_axis_tready = en;

	// Unpack channels, red in the lowest bits.
	assign ch_in[0] = s_axis_tdata[CH_W-1:0];
	assign ch_in[1] = s_axis_tdata[2*CH_W-1:CH_W];
	assign ch_in[2] = s_axis_tdata[3*CH_W-1:2*CH_W];

	// Valid bits travel alongside the data; a bubble takes a slot too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LATENCY; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_axis_tvalid;
			for (int i = 1; i < LATENCY; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Carry the last flag down the pipe with its pixel.
	always_ff @(posedge clk) begin
		if (en) begin
			last_q[0] <= s_axis_tlast;
			for (int i = 1; i < LATENCY; i++) begin
				last_q[i] <= last_q[i-1];
			end
		end
	end

	// One curve unit and one divider per channel.
	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [DW-1:0] num, den;

		acesfm_curve #(
			.FRAC_BITS (FRAC_BITS),
			.DW        (DW)
		) u_curve (
			.clk (clk),
			.en  (en),
			.x   (ch_in[c]),
			.num (num),
			.den (den)
		);

		acesfm_div #(
			.DW (DW)
		) u_div (
			.clk    (clk),
			.en     (en),
			.num    (num),
			.den    (den),
			.result (ch_out[c])
		);
	end

	// Pack the result beat, zero fill to whole bytes.
	assign m_axis_tvalid = vld_q[LATENCY-1];
	assign m_axis_tlast  = last_q[LATENCY-1];
	assign m_axis_tdata  = {(OUT_TDATA_W-3*OUT_W)'(0), ch_out[2], ch_out[1], ch_out[0]};

	// Red and blue results never exceed 1.0.
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:0] <= OUT_ONE))
		else $error("red result above one");

	a_blue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3*OUT_W-1:2*OUT_W] <= OUT_ONE))
		else $error("blue result above one");

	// An empty output slot never blocks the input side.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input held while output slot empty");

	// An accepted beat lands in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted beat lost at pipe entry");

	// A stalled output beat stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

// ===== sim/aces_filmic_tone_map_tb.sv =====
// ----------------------------------------------------------------------------
// ACES filmic tone map - testbench
// Streams linear HDR pixels into the tone mapper and checks every output
// beat against an exact integer model of the rational curve. Stalls on both
// sides, a full drain pause and a back-to-back burst cover the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aces_filmic_tone_map_tb;
	import acesfm_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
		logic             last;
	} tone_pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b1;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // red_in, green_in, blue_in
	logic                   s_axis_tlast = 1'b0; // last_in
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // red_out, green_out, blue_out, pad
	logic                   m_axis_tlast;        // last_out

	tone_pixel_t mapped_pixels[$];
	int unsigned mismatches = 0;
	bit          allow_stalls = 1'b1;

	aces_filmic_tone_map dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("aces_filmic_tone_map_tb failed");
		$finish;
	end

	// Exact ratio N/D scaled to Q1.16, rounded half up, saturated at 1.0.
	function automatic logic [OUT_W-1:0] tone_curve(input logic [CH_W-1:0] x);
		logic [127:0] one_in, xx, xs, num, den, quo;
		one_in = 128'd1 << DEF_FRAC_BITS;
		xx     = 128'(x) * 128'(x);
		xs     = 128'(x) * one_in;
		num    = C_NUM_SQ * xx + C_NUM_LIN * xs;
		den    = C_DEN_SQ * xx + C_DEN_LIN * xs + C_DEN_K * one_in * one_in;
		if (num >= den) begin
			return OUT_ONE;
		end
		quo = ((num << (QUO_BITS + 1)) + den) / (den << 1);
		if (quo > OUT_ONE) begin
			quo = OUT_ONE;
		end
		return quo[OUT_W-1:0];
	endfunction

	// Record the expected pixel on every input beat, check every output beat.
	always @(posedge clk) begin
		tone_pixel_t want, got;
		if (s_axis_tvalid && s_axis_tready) begin
			want.red   = tone_curve(s_axis_tdata[CH_W-1:0]);
			want.green = tone_curve(s_axis_tdata[2*CH_W-1:CH_W]);
			want.blue  = tone_curve(s_axis_tdata[3*CH_W-1:2*CH_W]);
			want.last  = s_axis_tlast;
			mapped_pixels.push_back(want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.red   = m_axis_tdata[OUT_W-1:0];
			got.green = m_axis_tdata[2*OUT_W-1:OUT_W];
			got.blue  = m_axis_tdata[3*OUT_W-1:2*OUT_W];
			got.last  = m_axis_tlast;
			if (mapped_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output beat, expected none, got %h", $time, got);
			end else begin
				want = mapped_pixels.pop_front();
				if (got.red !== want.red) begin
					mismatches++;
					$display("%0t: red mismatch, expected %0d, got %0d",
						$time, want.red, got.red);
				end
				if (got.green !== want.green) begin
					mismatches++;
					$display("%0t: green mismatch, expected %0d, got %0d",
						$time, want.green, got.green);
				end
				if (got.blue !== want.blue) begin
					mismatches++;
					$display("%0t: blue mismatch, expected %0d, got %0d",
						$time, want.blue, got.blue);
				end
				if (got.last !== want.last) begin
					mismatches++;
					$display("%0t: last mismatch, expected %0d, got %0d",
						$time, want.last, got.last);
				end
			end
		end
	end

	// Receiver: ready in random runs, dropped in random bursts between them.
	initial begin
		@(posedge arst_n);
		forever begin
			if (allow_stalls && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// Drive one pixel and hold it until the beat is taken.
	task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
		input logic [CH_W-1:0] blue, input logic last);
		if (allow_stalls && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {blue, green, red};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Channel values weighted toward the interesting parts of the curve.
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 5))
			0:       return CH_W'($urandom_range(0, 255));
			1:       return CH_W'($urandom_range(0, 4 << DEF_FRAC_BITS));
			2:       return CH_W'($urandom_range(465000, 485000));  // around the saturation knee
			3:       return CH_W'($urandom_range(0, 16 << DEF_FRAC_BITS));
			default: return CH_W'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		send_pixel('0, '0, '0, 1'b0);
		send_pixel('1, '1, '1, 1'b1);
		send_pixel(24'd1, 24'd1 << DEF_FRAC_BITS, '1, 1'b0);
		send_pixel(24'h800000, 24'h7FFFFF, 24'h555555, 1'b0);
		send_pixel(24'hAAAAAA, 24'h000002, 24'h00FFFF, 1'b1);
		send_pixel(24'h010000 >> 1, 24'h020000, 24'h100000, 1'b0);
	endtask

	// Sweep across the point where the curve crosses one, including the
	// band just below it that rounds up to full scale.
	task automatic test_saturation_knee();
		logic [CH_W-1:0] x;
		for (int i = 0; i < 12; i++) begin
			x = CH_W'(471000 + i * 700);
			send_pixel(x, x + 24'd1, x - 24'd1, (i == 11));
		end
	endtask

	// Hold the sender until the pipe has drained completely.
	task automatic test_drain_pause();
		for (int i = 0; i < 8; i++) begin
			send_pixel(pick_channel(), pick_channel(), pick_channel(), (i == 7));
		end
		s_axis_tvalid <= 1'b0;
		wait (mapped_pixels.size() == 0);
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			send_pixel(pick_channel(), pick_channel(), pick_channel(), (i == 7));
		end
	endtask

	// Runs of random length, last flag on the closing pixel, inverted at random on any pixel.
	task automatic test_random_runs(input int unsigned pixel_count);
		int unsigned sent, run_len;
		sent = 0;
		while (sent < pixel_count) begin
			run_len = $urandom_range(1, 16);
			for (int unsigned k = 0; k < run_len; k++) begin
				send_pixel(pick_channel(), pick_channel(), pick_channel(),
					(k == run_len - 1) ^ ($urandom_range(0, 15) == 0));
			end
			sent += run_len;
		end
	endtask

	// Back-to-back beats with the receiver always ready.
	task automatic test_full_rate();
		allow_stalls = 1'b0;
		test_random_runs(64);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_saturation_knee();
		test_drain_pause();
		test_random_runs(440);
		test_full_rate();

		s_axis_tvalid <= 1'b0;
		wait (mapped_pixels.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);

		if (mismatches == 0 && mapped_pixels.size() == 0) begin
			$display("aces_filmic_tone_map_tb passed");
		end else begin
			$display("aces_filmic_tone_map_tb failed");
		end
		$finish;
	end

endmodule
